// ===== design/dtb_pkg.sv =====
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared types and character constants of the decimal to binary text rewriter.
// ----------------------------------------------------------------------------
package dtb_pkg;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_ONE     = 8'h31;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_B       = 8'h62;
   localparam logic [7:0] CHAR_DOT     = 8'h2e;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

   // what one accepted item asks the emitter to write
   typedef struct packed {
      logic num;
      logic chr;
      logic eos;
   } cmd_type;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_PFX0    = 7'b0000010,
      ST_PFXB    = 7'b0000100,
      ST_BITS    = 7'b0001000,
      ST_CHAR    = 7'b0010000,
      ST_DOT     = 7'b0100000,
      ST_NEWLINE = 7'b1000000
   } state_type;

endpackage

// ===== design/dtb_accum.sv =====
// ----------------------------------------------------------------------------
// dtb_accum
// Decimal digit accumulator: value times ten plus digit, saturating.
// ----------------------------------------------------------------------------
module dtb_accum #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  is_digit,
   input  logic [3:0]            digit,
   input  logic                  eos,
   output logic                  pending,
   output logic [VALUE_BITS-1:0] number
);

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  pending_ff, pending_in;
   logic [VALUE_BITS+3:0] wide;
   logic [VALUE_BITS-1:0] sat_val;

   assign wide = ({4'b0, value_ff} << 3) + ({4'b0, value_ff} << 1)
               + {{VALUE_BITS{1'b0}}, digit};
   assign sat_val = (|wide[VALUE_BITS+3:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                     : wide[VALUE_BITS-1:0];
   assign number  = is_digit ? sat_val : value_ff;
   assign pending = pending_ff;

   always_comb begin
      value_in   = value_ff;
      pending_in = pending_ff;
      if (accept) begin
         if (is_digit && !eos) begin
            value_in   = sat_val;
            pending_in = 1'b1;
         end else begin
            value_in   = '0;
            pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         value_ff   <= value_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ===== design/dtb_emit.sv =====
// ----------------------------------------------------------------------------
// dtb_emit
// Character sequencer: prefix, binary digits from a shift register, the
// passed character and the sentence tail, into an output register.
// ----------------------------------------------------------------------------
module dtb_emit #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  dtb_pkg::cmd_type      cmd,
   input  logic [7:0]            char_code,
   input  logic [VALUE_BITS-1:0] number,
   output logic                  idle,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_last_of_run
);

   localparam int CNT_W = $clog2(VALUE_BITS);

   dtb_pkg::state_type    state_ff, state_in;
   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  seen_ff, seen_in;
   logic                  chr_ff, chr_in;
   logic                  eos_ff, eos_in;
   logic [7:0]            char_ff, char_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            out_ff, out_in;
   logic                  last_ff, last_in;

   logic adv;
   logic bit_one;
   logic final_bit;
   logic show;

   assign adv       = !valid_ff || rsp_ready;
   assign bit_one   = shift_ff[VALUE_BITS-1];
   assign final_bit = (cnt_ff == CNT_W'(VALUE_BITS - 1));
   assign show      = bit_one || seen_ff || final_bit;

   assign idle            = (state_ff == dtb_pkg::ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_out_char    = out_ff;
   assign rsp_last_of_run = last_ff;

   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      seen_in  = seen_ff;
      chr_in   = chr_ff;
      eos_in   = eos_ff;
      char_in  = char_ff;
      valid_in = valid_ff && !rsp_ready;
      out_in   = out_ff;
      last_in  = last_ff;
      case (state_ff)
         dtb_pkg::ST_IDLE: begin
            if (start) begin
               shift_in = number;
               cnt_in   = '0;
               seen_in  = 1'b0;
               chr_in   = cmd.chr;
               eos_in   = cmd.eos;
               char_in  = char_code;
               if (cmd.num)
                  state_in = dtb_pkg::ST_PFX0;
               else if (cmd.chr)
                  state_in = dtb_pkg::ST_CHAR;
               else if (cmd.eos)
                  state_in = dtb_pkg::ST_DOT;
               else
                  state_in = dtb_pkg::ST_IDLE;
            end
         end
         dtb_pkg::ST_PFX0: begin
            if (adv) begin
               valid_in = 1'b1;
               out_in   = dtb_pkg::CHAR_ZERO;
               last_in  = 1'b0;
               state_in = dtb_pkg::ST_PFXB;
            end
         end
         dtb_pkg::ST_PFXB: begin
            if (adv) begin
               valid_in = 1'b1;
               out_in   = dtb_pkg::CHAR_B;
               last_in  = 1'b0;
               state_in = dtb_pkg::ST_BITS;
            end
         end
         dtb_pkg::ST_BITS: begin
            if (!show || adv) begin
               if (show) begin
                  valid_in = 1'b1;
                  out_in   = bit_one ? dtb_pkg::CHAR_ONE : dtb_pkg::CHAR_ZERO;
                  last_in  = final_bit && !chr_ff && !eos_ff;
               end
               shift_in = shift_ff << 1;
               cnt_in   = cnt_ff + CNT_W'(1);
               seen_in  = seen_ff || bit_one;
               if (final_bit) begin
                  if (chr_ff)
                     state_in = dtb_pkg::ST_CHAR;
                  else if (eos_ff)
                     state_in = dtb_pkg::ST_DOT;
                  else
                     state_in = dtb_pkg::ST_IDLE;
               end
            end
         end
         dtb_pkg::ST_CHAR: begin
            if (adv) begin
               valid_in = 1'b1;
               out_in   = char_ff;
               last_in  = !eos_ff;
               state_in = eos_ff ? dtb_pkg::ST_DOT : dtb_pkg::ST_IDLE;
            end
         end
         dtb_pkg::ST_DOT: begin
            if (adv) begin
               valid_in = 1'b1;
               out_in   = dtb_pkg::CHAR_DOT;
               last_in  = 1'b0;
               state_in = dtb_pkg::ST_NEWLINE;
            end
         end
         dtb_pkg::ST_NEWLINE: begin
            if (adv) begin
               valid_in = 1'b1;
               out_in   = dtb_pkg::CHAR_NEWLINE;
               last_in  = 1'b1;
               state_in = dtb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtb_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
      seen_ff  <= seen_in;
      chr_ff   <= chr_in;
      eos_ff   <= eos_in;
      char_ff  <= char_in;
      out_ff   <= out_in;
      last_ff  <= last_in;
   end

endmodule

// ===== design/decimal_to_binary_text_rewriter.sv =====
// ----------------------------------------------------------------------------
// decimal_to_binary_text_rewriter
// Rewrites decimal digit runs of a sentence as 0b-prefixed binary text and
// closes each sentence with a period and newline.
//
//   channel  dir  handshake             payload
//   req_     in   req_valid/req_ready   req_char_code, req_end_of_sentence
//   rsp_     out  rsp_valid/rsp_ready   rsp_out_char, rsp_last_of_run
//
// a digit item that does not end the sentence only updates the accumulator
// other items keep the sequencer busy until their last character is registered; a number scans
// all VALUE_BITS positions of its shift register, one bit per cycle unless rsp_ready stalls
// req_ready is high only while the sequencer is idle
// reset clears the accumulator, the sequencer state and the output valid flag
// a stalled rsp_ready holds the current character and pauses the sequence
// ----------------------------------------------------------------------------
module decimal_to_binary_text_rewriter #(
   parameter int VALUE_BITS = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_sentence,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   logic                  accept;
   logic                  is_digit;
   logic                  pending;
   logic                  idle;
   logic [VALUE_BITS-1:0] number;
   dtb_pkg::cmd_type      cmd;

   assign req_ready = idle;
   assign accept    = req_valid && idle;
   assign is_digit  = (req_char_code >= dtb_pkg::CHAR_ZERO)
                   && (req_char_code <= dtb_pkg::CHAR_NINE);

   assign cmd.num = is_digit ? req_end_of_sentence : pending;
   assign cmd.chr = !is_digit;
   assign cmd.eos = req_end_of_sentence;

   dtb_accum #(
      .VALUE_BITS(VALUE_BITS)
   ) u_accum (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .is_digit (is_digit),
      .digit    (req_char_code[3:0]),
      .eos      (req_end_of_sentence),
      .pending  (pending),
      .number   (number)
   );

   dtb_emit #(
      .VALUE_BITS(VALUE_BITS)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .start           (accept),
      .cmd             (cmd),
      .char_code       (req_char_code),
      .number          (number),
      .idle            (idle),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== design/dtb_checker.sv =====
// ----------------------------------------------------------------------------
// dtb_checker
// Port-level checks of the rewriter, bound to the top level.
// ----------------------------------------------------------------------------
module dtb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_char_code,
   input logic       req_end_of_sentence,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last_of_run
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_char) && $stable(rsp_last_of_run))
      else $error("rsp item changed while stalled");

   // no new item while the current one still has characters to come
   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("req_ready high in the middle of an item");

   // a non-digit always produces output, so the block must go busy
   a_nondigit_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready
         && (req_char_code < dtb_pkg::CHAR_ZERO || req_char_code > dtb_pkg::CHAR_NINE)
         |=> !req_ready)
      else $error("non-digit item did not start output");

   // sentence end always produces output
   a_eos_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_sentence |=> !req_ready)
      else $error("sentence end did not start output");

endmodule

bind decimal_to_binary_text_rewriter dtb_checker u_dtb_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .req_char_code       (req_char_code),
   .req_end_of_sentence (req_end_of_sentence),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_out_char        (rsp_out_char),
   .rsp_last_of_run     (rsp_last_of_run)
);
